/* src/tach_pkg.sv */
// ----------------------------------------------------------------------------
// tach_pkg: shared types and constants of the tachometer speed meter
// Holds the input mode codes, the divider geometry and the control and status
// structs that pass between the sequencer and the divider.
// ----------------------------------------------------------------------------
package tach_pkg;

  localparam int unsigned CntWidth   = 32;
  localparam int unsigned NumWidth   = 64;
  localparam int unsigned DenWidth   = 32;
  localparam int unsigned DivSteps   = NumWidth;
  localparam int unsigned StepWidth  = $clog2(DivSteps);

  // 60 s * 16 MHz / 2 pulses per revolution.
  localparam logic [31:0] RpmScaleReset = 32'd480000000;

  localparam logic ModeEdge   = 1'b0;
  localparam logic ModeUpdate = 1'b1;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* src/tach_if.sv */
// ----------------------------------------------------------------------------
// tach_if: valid/ready channels of the tachometer speed meter
// The event channel carries an edge or update item; the result channel
// carries one speed measurement.
// ----------------------------------------------------------------------------
interface tach_evt_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] time_stamp;

  modport source (output valid, output mode, output time_stamp, input ready);
  modport sink   (input valid, input mode, input time_stamp, output ready);
endinterface

interface tach_res_if #(
  parameter int unsigned RPM_WIDTH = 24
);
  logic                 valid;
  logic                 ready;
  logic [RPM_WIDTH-1:0] rpm;
  logic                 saturated;
  logic                 stalled;

  modport source (output valid, output rpm, output saturated, output stalled,
                  input ready);
  modport sink   (input valid, input rpm, input saturated, input stalled,
                  output ready);
endinterface

/* src/tach_divider.sv */
// ----------------------------------------------------------------------------
// tach_divider: iterative restoring divider
// Divides a 64-bit numerator by a nonzero 32-bit denominator, one quotient
// bit per cycle, and pulses done when the full quotient is ready.
// ----------------------------------------------------------------------------
module tach_divider import tach_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  div_ctrl_t           ctrl_i,
  input  logic [NumWidth-1:0] num_i,
  input  logic [DenWidth-1:0] den_i,
  output div_stat_t           stat_o,
  output logic [NumWidth-1:0] quot_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [StepWidth-1:0] step_q, step_d;
  logic [DenWidth-1:0]  rem_q, rem_d;
  logic [DenWidth-1:0]  den_q, den_d;
  logic [NumWidth-1:0]  dvd_q, dvd_d;
  logic [DenWidth+1:0]  diff;

  // Trial subtraction of the denominator from the shifted partial remainder.
  assign diff = {1'b0, rem_q, dvd_q[NumWidth-1]} - {2'b00, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    den_d  = den_q;
    dvd_d  = dvd_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      step_d = StepWidth'(DivSteps - 1);
      rem_d  = '0;
      den_d  = den_i;
      dvd_d  = num_i;
    end else if (busy_q) begin
      if (diff[DenWidth+1]) begin
        rem_d = {rem_q[DenWidth-2:0], dvd_q[NumWidth-1]};
      end else begin
        rem_d = diff[DenWidth-1:0];
      end
      dvd_d  = {dvd_q[NumWidth-2:0], ~diff[DenWidth+1]};
      step_d = step_q - 1'b1;
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    dvd_q <= dvd_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = dvd_q;

endmodule

/* src/tach_rpm_meter.sv */
// ----------------------------------------------------------------------------
// tach_rpm_meter: fan tachometer speed meter
// Counts tach edges and, on request, reports rpm = scale * pulses / ticks.
// ----------------------------------------------------------------------------
// Usage: each transaction on in_ch is either a tach edge (mode 0) or an
// update request (mode 1), both stamped with the free-running timer. An edge
// is absorbed in its accept cycle and produces nothing. An update produces
// one transaction on out_ch carrying rpm, a saturated flag and a stalled
// flag. An update runs through the sequencer states in order: the multiply
// state forms the product and loads the divider, the divide state waits on
// the one-bit-per-cycle restoring divider and takes the quotient once it
// signals done, and the post state moves the result to the output register.
// With zero elapsed time the divider is skipped and the sequencer goes from
// idle straight to the post state. in_ch is not ready while an update is in
// flight, so the next transaction is taken only once the update has left the
// post state; edges go one per cycle while none is in flight. The result
// sits in an output register, so further edges are taken while it waits; a
// finished update waits for that register to drain when out_ch stalls. The
// scale register is written through cfg_we_i and cfg_wdata_i; the user must
// write it only while the block is idle, as the block does not enforce this.
// Reset clears the counters and the reference edge and loads the default scale.
// ----------------------------------------------------------------------------
module tach_rpm_meter import tach_pkg::*; #(
  parameter int unsigned RPM_WIDTH = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  tach_evt_if.sink    in_ch,
  tach_res_if.source  out_ch
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StPost = 3'd3;

  logic [2:0]          state_q, state_d;
  logic [31:0]         rpm_scale_q;
  logic [CntWidth-1:0] edge_count_q, last_edge_time_q;
  logic [CntWidth-1:0] ref_edge_count_q, ref_edge_time_q;
  logic [CntWidth-1:0] pulses_q, ticks_q;
  logic                stall_q;
  logic [RPM_WIDTH-1:0] res_rpm_q;
  logic                res_sat_q;
  logic [CntWidth-1:0] new_pulses;
  logic                in_fire, upd_fire;
  logic                out_free;
  div_ctrl_t           div_ctrl;
  div_stat_t           div_stat;
  logic [NumWidth-1:0] product;
  logic [NumWidth-1:0] quot;

  logic                 out_valid_q;
  logic [RPM_WIDTH-1:0] out_rpm_q;
  logic                 out_sat_q;
  logic                 out_stall_q;

  assign in_ch.ready = (state_q == StIdle);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign upd_fire    = in_fire && (in_ch.mode == ModeUpdate);
  assign new_pulses  = edge_count_q - ref_edge_count_q;
  assign out_free    = !out_valid_q || out_ch.ready;

  assign product        = NumWidth'(rpm_scale_q) * NumWidth'(pulses_q);
  assign div_ctrl.start = (state_q == StMul);

  tach_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .num_i  (product),
    .den_i  (ticks_q),
    .stat_o (div_stat),
    .quot_o (quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (upd_fire) begin
          state_d = (new_pulses == '0 ? (in_ch.time_stamp - ref_edge_time_q)
                                      : (last_edge_time_q - ref_edge_time_q)) == '0
                    ? StPost : StMul;
        end
      end
      StMul:   state_d = StDiv;
      StDiv:   if (div_stat.done) state_d = StPost;
      StPost:  if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= StIdle;
      rpm_scale_q      <= RpmScaleReset;
      edge_count_q     <= '0;
      last_edge_time_q <= '0;
      ref_edge_count_q <= '0;
      ref_edge_time_q  <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        rpm_scale_q <= cfg_wdata_i;
      end
      if (in_fire && (in_ch.mode == ModeEdge)) begin
        edge_count_q     <= edge_count_q + 1'b1;
        last_edge_time_q <= in_ch.time_stamp;
      end
      // The reference advances only when new edges came in.
      if (upd_fire && (new_pulses != '0)) begin
        ref_edge_count_q <= edge_count_q;
        ref_edge_time_q  <= last_edge_time_q;
      end
      if (state_q == StPost && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_fire) begin
      if (new_pulses == '0) begin
        pulses_q <= CntWidth'(1);
        ticks_q  <= in_ch.time_stamp - ref_edge_time_q;
        stall_q  <= 1'b1;
      end else begin
        pulses_q <= new_pulses;
        ticks_q  <= last_edge_time_q - ref_edge_time_q;
        stall_q  <= 1'b0;
      end
      // Zero elapsed time skips the divider with a saturated result.
      res_rpm_q <= '1;
      res_sat_q <= 1'b1;
    end
    if (state_q == StDiv && div_stat.done) begin
      if (quot[NumWidth-1:RPM_WIDTH] != '0) begin
        res_rpm_q <= '1;
        res_sat_q <= 1'b1;
      end else begin
        res_rpm_q <= quot[RPM_WIDTH-1:0];
        res_sat_q <= 1'b0;
      end
    end
    if (state_q == StPost && out_free) begin
      out_rpm_q   <= res_rpm_q;
      out_sat_q   <= res_sat_q;
      out_stall_q <= stall_q;
    end
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.rpm       = out_rpm_q;
  assign out_ch.saturated = out_sat_q;
  assign out_ch.stalled   = out_stall_q;

  // The event channel is never ready while the divider is running.
  a_ready_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.ready |-> !div_stat.busy)
    else $error("event channel ready while divider busy");

  // The divider finishes only while the sequencer waits for it.
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == StDiv))
    else $error("divider done outside the divide state");

  // The divider is never started with a zero denominator.
  a_no_zero_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMul) |-> (ticks_q != '0))
    else $error("divider started with zero elapsed time");

  // A saturated result always carries the full-scale rpm value.
  a_sat_full_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.saturated) |-> (out_ch.rpm == {RPM_WIDTH{1'b1}}))
    else $error("saturated result without full-scale rpm");

endmodule
